@@ design/gcr_pkg.sv @@
// Shared constants, types, the sine table and the sine lookup of the grid column raycaster.
package gcr_pkg;

    localparam int MAP_WIDTH  = 32;
    localparam int MAP_HEIGHT = 32;
    localparam int SINE_DEPTH = 256;
    localparam int MAP_COL_W  = $clog2(MAP_WIDTH);
    localparam int MAP_ROW_W  = $clog2(MAP_HEIGHT);
    localparam int SINE_IDX_W = $clog2(SINE_DEPTH) + 1;

    // March step of 41/4096 cell and the depth limit of 16 cells, both Q12.
    localparam logic [16:0] STEP_Q12  = 17'd41;
    localparam logic [16:0] DEPTH_Q12 = 17'd65536;
    localparam logic [16:0] HALF_FOV  = 17'd4096;
    localparam logic [16:0] DIST_TWO  = 17'd8192;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Shared divider sizes.
    localparam int DIV_N_W   = 25;
    localparam int DIV_D_W   = 18;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    // Configuration register indexes.
    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_CAST = 1'b1;

    typedef logic [14:0] sine_tab_t [SINE_DEPTH];

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cast_go;
        logic trig;
        logic step0;
        logic test;
        logic cmul;
        logic cdiv_go;
        logic emit;
    } gcr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic march_stop;
        logic ceil_pos;
    } gcr_stat_t;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_ANG  = 8'b0000_0010,
        ST_TRIG = 8'b0000_0100,
        ST_STEP = 8'b0000_1000,
        ST_TEST = 8'b0001_0000,
        ST_CMUL = 8'b0010_0000,
        ST_CSEL = 8'b0100_0000,
        ST_CDIV = 8'b1000_0000
    } gcr_state_t;

    // Quarter-wave sine in Q15, built from a Q30 Taylor series at elaboration.
    function automatic sine_tab_t build_sine();
        sine_tab_t tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] r;
        logic signed [63:0] sum;
        for (int k = 0; k < SINE_DEPTH; k++)
        begin
            x    = (64'(k) * HALF_PI_Q30) / 64'(SINE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 5; n++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
            if (sum < 0)
                sum = 64'sd0;
            r = ($unsigned(sum) + 64'd16384) >> 15;
            if (r > 64'd32767)
                r = 64'd32767;
            tab[k] = r[14:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();

    // Full-turn sine from the quarter table, Q1.15 signed.
    function automatic logic signed [16:0] sine_of(input logic [15:0] a);
        logic [SINE_IDX_W+13:0] prod;
        logic [SINE_IDX_W-1:0]  i;
        logic [SINE_IDX_W-1:0]  j;
        logic [14:0]            mag;
        prod = {{SINE_IDX_W{1'b0}}, a[13:0]} * (SINE_IDX_W + 14)'(SINE_DEPTH);
        i    = prod[SINE_IDX_W+13:14];
        j    = a[14] ? (SINE_IDX_W'(SINE_DEPTH) - i) : i;
        if (j >= SINE_IDX_W'(SINE_DEPTH))
            mag = 15'h7FFF;
        else
            mag = SINE_TAB[j[SINE_IDX_W-2:0]];
        if (a[15])
            return -$signed({2'b00, mag});
        else
            return $signed({2'b00, mag});
    endfunction

endpackage

@@ design/gcr_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the angle and ceiling steps.
module gcr_div
    import gcr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic [DIV_N_W-1:0] quotient,
    output logic               done
);

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   den_reg, den_next;
    logic [DIV_D_W:0]     rem_sh;
    logic                 fits;

    // One shift and trial subtract per cycle.
    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DIV_N_W-1]};
        fits      = rem_sh >= {1'b0, den_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend;
            den_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = fits ? DIV_D_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_D_W-1:0];
            quo_next = {quo_reg[DIV_N_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_N_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ design/gcr_dp.sv @@
// Datapath: wall map, ray setup, fixed-step march, face test and ceiling arithmetic.
module gcr_dp
    import gcr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  gcr_cmd_t            cmd,
    output gcr_stat_t           stat,
    input  logic                map_we,
    input  logic [4:0]          row_index,
    input  logic [31:0]         row_bits,
    input  logic [15:0]         player_x,
    input  logic [15:0]         player_y,
    input  logic [15:0]         view_angle,
    input  logic [9:0]          screen_column,
    input  logic [9:0]          width_cfg,
    input  logic [8:0]          height_cfg,
    output logic                done,
    output logic [9:0]          out_column,
    output logic                wall_hit,
    output logic [16:0]         wall_distance,
    output logic [11:0]         texture_u,
    output logic signed [8:0]   ceiling_row,
    output logic [9:0]          floor_row
);

    logic [MAP_WIDTH-1:0] map_reg [MAP_HEIGHT];

    logic [15:0]        px_reg, py_reg, view_reg;
    logic [9:0]         col_reg;
    logic signed [21:0] stx_reg, sty_reg;
    logic signed [35:0] posx_reg, posy_reg;
    logic [16:0]        d_reg;
    logic               hit_reg;
    logic [11:0]        u_reg;
    logic [16:0]        dist_reg;
    logic [25:0]        prod_reg;
    logic [17:0]        den_reg;
    logic               cpos_reg;
    logic               done_reg;
    logic [9:0]         ocol_reg;
    logic               ohit_reg;
    logic [16:0]        odist_reg;
    logic [11:0]        ou_reg;
    logic [8:0]         oceil_reg;
    logic [9:0]         ofloor_reg;

    logic [DIV_N_W-1:0] div_n;
    logic [DIV_D_W-1:0] div_d;
    logic [DIV_N_W-1:0] div_q;
    logic               div_done;
    logic [9:0]         w_eff;
    logic [15:0]        ang;
    logic signed [16:0] ex, ey;

    logic               neg, outside, wall, depth_end, stop;
    logic [8:0]         cx, cy;
    logic signed [27:0] dx, dy;
    logic [27:0]        ax, ay;
    logic               use_x;
    logic [16:0]        dist_next;
    logic [16:0]        ddiff;
    logic [8:0]         ceil_next;

    // Shared divider: column angle at cast start, ceiling row later.
    assign w_eff = (width_cfg == 10'd0) ? 10'd1 : width_cfg;
    assign div_n = cmd.cast_go ? DIV_N_W'({screen_column, 13'd0}) : DIV_N_W'(prod_reg);
    assign div_d = cmd.cast_go ? DIV_D_W'(w_eff) : den_reg;

    gcr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.cast_go || cmd.cdiv_go),
        .dividend (div_n),
        .divisor  (div_d),
        .quotient (div_q),
        .done     (div_done)
    );

    // Ray angle and direction.
    assign ang = view_reg - HALF_FOV[15:0] + div_q[15:0];
    assign ex  = sine_of(ang + 16'h4000);
    assign ey  = sine_of(ang);

    // Cell and wall test on the current march point.
    assign neg       = posx_reg[35] || posy_reg[35];
    assign cx        = posx_reg[35:27];
    assign cy        = posy_reg[35:27];
    assign outside   = (cx >= 9'(MAP_WIDTH)) || (cy >= 9'(MAP_HEIGHT));
    assign wall      = map_reg[cy[MAP_ROW_W-1:0]][cx[MAP_COL_W-1:0]];
    assign depth_end = d_reg >= DEPTH_Q12;
    assign stop      = neg || outside || wall || depth_end;

    // Face choice by offset magnitude from the cell center.
    assign dx    = $signed({1'b0, posx_reg[26:0]}) - 28'sd67108864;
    assign dy    = $signed({1'b0, posy_reg[26:0]}) - 28'sd67108864;
    assign ax    = dx[27] ? 28'(-dx) : 28'(dx);
    assign ay    = dy[27] ? 28'(-dy) : 28'(dy);
    assign use_x = (ay > ax) || ((ay == ax) && (dx == dy) && (dx != 28'sd0));

    // A hit that is past depth reports the depth.
    assign dist_next = (!neg && !outside && wall && (d_reg <= DEPTH_Q12)) ? d_reg : DEPTH_Q12;
    assign ddiff     = (dist_reg >= DIST_TWO) ? (dist_reg - DIST_TWO) : (DIST_TWO - dist_reg);

    // Ceiling row: quotient above the horizon, zero or minus one below.
    always_comb
    begin
        if (cpos_reg)
            ceil_next = div_q[8:0];
        else if (prod_reg < 26'(den_reg))
            ceil_next = 9'd0;
        else
            ceil_next = 9'h1FF;
    end

    // Wall map rows.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAP_HEIGHT; r++)
            begin
                map_reg[r] <= '0;
            end
        end
        else if (map_we && (32'(row_index) < 32'(MAP_HEIGHT)))
        begin
            map_reg[row_index[MAP_ROW_W-1:0]] <= row_bits[MAP_WIDTH-1:0];
        end
    end

    // Cast working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.cast_go)
        begin
            px_reg   <= player_x;
            py_reg   <= player_y;
            view_reg <= view_angle;
            col_reg  <= screen_column;
        end
        if (cmd.trig)
        begin
            stx_reg <= 22'(ex * 17'sd41);
            sty_reg <= 22'(ey * 17'sd41);
        end
        if (cmd.step0)
        begin
            posx_reg <= $signed({4'd0, px_reg, 16'd0}) + 36'(stx_reg);
            posy_reg <= $signed({4'd0, py_reg, 16'd0}) + 36'(sty_reg);
            d_reg    <= STEP_Q12;
            hit_reg  <= 1'b0;
        end
        else if (cmd.test)
        begin
            if (stop)
            begin
                hit_reg  <= !neg && !outside && wall;
                u_reg    <= use_x ? posx_reg[26:15] : posy_reg[26:15];
                dist_reg <= dist_next;
            end
            else
            begin
                posx_reg <= posx_reg + 36'(stx_reg);
                posy_reg <= posy_reg + 36'(sty_reg);
                d_reg    <= d_reg + STEP_Q12;
            end
        end
        if (cmd.cmul)
        begin
            prod_reg <= 26'(height_cfg * ddiff);
            den_reg  <= {dist_reg, 1'b0};
            cpos_reg <= dist_reg >= DIST_TWO;
        end
        if (cmd.emit)
        begin
            ocol_reg   <= col_reg;
            ohit_reg   <= hit_reg;
            odist_reg  <= dist_reg;
            ou_reg     <= hit_reg ? u_reg : 12'd0;
            oceil_reg  <= ceil_next;
            ofloor_reg <= {1'b0, height_cfg} - {ceil_next[8], ceil_next};
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.emit;
    end

    assign stat.div_done   = div_done;
    assign stat.march_stop = stop;
    assign stat.ceil_pos   = cpos_reg;

    assign done          = done_reg;
    assign out_column    = ocol_reg;
    assign wall_hit      = ohit_reg;
    assign wall_distance = odist_reg;
    assign texture_u     = ou_reg;
    assign ceiling_row   = $signed(oceil_reg);
    assign floor_row     = ofloor_reg;

endmodule

@@ design/gcr_ctrl.sv @@
// Controller state machine that sequences one request through the datapath.
module gcr_ctrl
    import gcr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      action,
    input  gcr_stat_t stat,
    output gcr_cmd_t  cmd,
    output logic      map_we,
    output logic      busy
);

    gcr_state_t state_reg, state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        map_we     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_CAST)
                    begin
                        cmd.cast_go = 1'b1;
                        state_next  = ST_ANG;
                    end
                    else
                    begin
                        map_we = 1'b1;
                    end
                end
            end
            ST_ANG:
            begin
                if (stat.div_done)
                    state_next = ST_TRIG;
            end
            ST_TRIG:
            begin
                cmd.trig   = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.step0  = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                cmd.test = 1'b1;
                if (stat.march_stop)
                    state_next = ST_CMUL;
            end
            ST_CMUL:
            begin
                cmd.cmul   = 1'b1;
                state_next = ST_CSEL;
            end
            ST_CSEL:
            begin
                if (stat.ceil_pos)
                begin
                    cmd.cdiv_go = 1'b1;
                    state_next  = ST_CDIV;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = state_reg != ST_IDLE;

endmodule

@@ design/grid_column_raycaster_top.sv @@
// Top level of the grid column raycaster: configuration registers, controller and datapath.
//
// A request is taken on a clock edge with start high and busy low. With action 0 it
// writes row_bits into map row row_index in that one edge; busy stays low and no
// result follows. With action 1 it casts the ray for screen_column from the viewer
// at player_x, player_y facing view_angle. One result per cast appears on the result
// ports, marked by done, which is high for exactly one cycle; the receiver cannot stall it.
// A cast runs the column-angle division, the setup states, one march step per cycle
// (at most 1600 steps of 41/4096 cell to depth 16) and, when the reported distance
// is at least two cells, the ceiling division. busy stays high throughout,
// and a new request is taken in the cycle done is shown.
// The configuration channel writes screen_width (index 0) and screen_height
// (index 1); cfg_ready is always high and writes are meant for idle periods.
// Reset clears the wall map, sets width 320 and height 180 and returns to idle.
module grid_column_raycaster_top
    import gcr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              action,
    input  logic [4:0]        row_index,
    input  logic [31:0]       row_bits,
    input  logic [15:0]       player_x,
    input  logic [15:0]       player_y,
    input  logic [15:0]       view_angle,
    input  logic [9:0]        screen_column,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_addr,
    input  logic [9:0]        cfg_data,
    output logic              done,
    output logic [9:0]        out_column,
    output logic              wall_hit,
    output logic [16:0]       wall_distance,
    output logic [11:0]       texture_u,
    output logic signed [8:0] ceiling_row,
    output logic [9:0]        floor_row
);

    logic [9:0] width_reg;
    logic [8:0] height_reg;
    gcr_cmd_t   cmd;
    gcr_stat_t  stat;
    logic       map_we;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 10'd320;
            height_reg <= 9'd180;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                CFG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: height_reg <= cfg_data[8:0];
                default:           ;
            endcase
        end
    end

    gcr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .cmd    (cmd),
        .map_we (map_we),
        .busy   (busy)
    );

    gcr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .map_we        (map_we),
        .row_index     (row_index),
        .row_bits      (row_bits),
        .player_x      (player_x),
        .player_y      (player_y),
        .view_angle    (view_angle),
        .screen_column (screen_column),
        .width_cfg     (width_reg),
        .height_cfg    (height_reg),
        .done          (done),
        .out_column    (out_column),
        .wall_hit      (wall_hit),
        .wall_distance (wall_distance),
        .texture_u     (texture_u),
        .ceiling_row   (ceiling_row),
        .floor_row     (floor_row)
    );

endmodule

@@ bench/gcr_checker.sv @@
// Checker for the grid column raycaster: predicts each cast result and compares it.
`timescale 1ns / 1ps

module gcr_checker
    import gcr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              action,
    input  logic [4:0]        row_index,
    input  logic [31:0]       row_bits,
    input  logic [15:0]       player_x,
    input  logic [15:0]       player_y,
    input  logic [15:0]       view_angle,
    input  logic [9:0]        screen_column,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_addr,
    input  logic [9:0]        cfg_data,
    input  logic              done,
    input  logic [9:0]        out_column,
    input  logic              wall_hit,
    input  logic [16:0]       wall_distance,
    input  logic [11:0]       texture_u,
    input  logic signed [8:0] ceiling_row,
    input  logic [9:0]        floor_row,
    output int                mismatch_count,
    output int                pending_count
);

    typedef struct packed {
        logic [9:0]  column;
        logic        hit;
        logic [16:0] distance;
        logic [11:0] tex_u;
        logic [8:0]  ceil_row;
        logic [9:0]  flr_row;
    } column_result_t;

    logic [31:0]    wall_rows [MAP_HEIGHT];
    logic [14:0]    quarter_wave [SINE_DEPTH];
    logic [9:0]     width_reg;
    logic [8:0]     height_reg;
    column_result_t column_queue [$];

    // One quarter-wave entry from an integer Taylor series in Q30.
    function automatic logic [14:0] quarter_entry(int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] r;
        longint      sum;
        x    = (64'(k) * HALF_PI_Q30) / 64'(SINE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 5; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = (64'(sum) + 64'd16384) >> 15;
        if (r > 64'd32767)
            r = 64'd32767;
        return r[14:0];
    endfunction

    // Full-turn sine in Q1.15 from the quarter table.
    function automatic longint sine_q15(longint a);
        longint q;
        longint i;
        longint j;
        longint mag;
        a = a & 16'hFFFF;
        q = a >> 14;
        i = ((a & 16'h3FFF) * SINE_DEPTH) >> 14;
        j = (q == 1 || q == 3) ? SINE_DEPTH - i : i;
        mag = (j >= SINE_DEPTH) ? 32767 : longint'(quarter_wave[j]);
        return (q >= 2) ? -mag : mag;
    endfunction

    // March one ray through the wall map and form the column result.
    function automatic column_result_t trace_column(logic [15:0] px, logic [15:0] py,
                                                    logic [15:0] view, logic [9:0] col);
        column_result_t res;
        longint w, ang, ex, ey, d, posx, posy, cx, cy, dx, dy, ax, ay, p;
        longint ray_len, hh, num, den, crow;
        bit     hit;
        bit     left;
        bit     use_x;
        logic [11:0] u;
        hit  = 0;
        left = 0;
        u    = '0;
        d    = 0;
        w    = (width_reg == 0) ? 1 : longint'(width_reg);
        ang  = (longint'(view) + 65536 - 4096 + (longint'(col) * 8192) / w) & 16'hFFFF;
        ex   = sine_q15(ang + 16384);
        ey   = sine_q15(ang);
        while (!hit && d < 65536)
        begin
            d    = d + 41;
            posx = (longint'(px) <<< 16) + ex * d;
            posy = (longint'(py) <<< 16) + ey * d;
            if (posx < 0 || posy < 0)
            begin
                left = 1;
                break;
            end
            cx = posx >>> 27;
            cy = posy >>> 27;
            if (cx >= MAP_WIDTH || cy >= MAP_HEIGHT)
            begin
                left = 1;
                break;
            end
            if (wall_rows[cy][cx])
            begin
                dx    = posx - (cx <<< 27) - (longint'(1) <<< 26);
                dy    = posy - (cy <<< 27) - (longint'(1) <<< 26);
                ax    = dx < 0 ? -dx : dx;
                ay    = dy < 0 ? -dy : dy;
                use_x = (ay > ax) || (ay == ax && dx == dy && dx != 0);
                p     = use_x ? posx : posy;
                hit   = 1;
                u     = 12'((p & ((longint'(1) <<< 27) - 1)) >>> 15);
            end
        end
        ray_len = (left || !hit || d > 65536) ? 65536 : d;
        hh      = longint'(height_reg);
        num     = hh * ray_len - 8192 * hh;
        den     = 2 * ray_len;
        if (num >= 0)
            crow = num / den;
        else
            crow = ((-num) / den == 0) ? 0 : -1;
        res.column   = col;
        res.hit      = hit;
        res.distance = 17'(ray_len);
        res.tex_u    = hit ? u : 12'd0;
        res.ceil_row = 9'(crow);
        res.flr_row  = 10'(hh - crow);
        return res;
    endfunction

    assign pending_count = column_queue.size();

    initial
    begin
        for (int k = 0; k < SINE_DEPTH; k++)
            quarter_wave[k] = quarter_entry(k);
        mismatch_count = 0;
    end

    // Track configuration, map loads and casts; compare every result strobe.
    always @(posedge clk or negedge rst_n)
    begin
        column_result_t exp_res;
        column_result_t got;
        if (!rst_n)
        begin
            for (int r = 0; r < MAP_HEIGHT; r++)
                wall_rows[r] <= '0;
            width_reg  <= 10'd320;
            height_reg <= 9'd180;
            column_queue.delete();
        end
        else
        begin
            if (done)
            begin
                got = '{out_column, wall_hit, wall_distance, texture_u,
                        ceiling_row, floor_row};
                if (column_queue.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("Unexpected result: column %0d", out_column);
                end
                else
                begin
                    exp_res = column_queue.pop_front();
                    if (got !== exp_res)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                        begin
                            $display("Column %0d: expected hit %0d dist %0d u %0d ceil %0d floor %0d",
                                     exp_res.column, exp_res.hit, exp_res.distance,
                                     exp_res.tex_u, $signed(exp_res.ceil_row),
                                     exp_res.flr_row);
                            $display("    got col %0d hit %0d dist %0d u %0d ceil %0d floor %0d",
                                     got.column, got.hit, got.distance,
                                     got.tex_u, $signed(got.ceil_row), got.flr_row);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                if (action == ACT_LOAD)
                    wall_rows[row_index] <= row_bits;
                else
                    column_queue.push_back(trace_column(player_x, player_y,
                                                        view_angle, screen_column));
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_addr == CFG_SCREEN_WIDTH)
                    width_reg <= cfg_data;
                else if (cfg_addr == CFG_SCREEN_HEIGHT)
                    height_reg <= cfg_data[8:0];
            end
        end
    end

endmodule

@@ bench/grid_column_raycaster_top_tb.sv @@
// Testbench top for the grid column raycaster: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module grid_column_raycaster_top_tb;
    import gcr_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              action;
    logic [4:0]        row_index;
    logic [31:0]       row_bits;
    logic [15:0]       player_x;
    logic [15:0]       player_y;
    logic [15:0]       view_angle;
    logic [9:0]        screen_column;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_addr;
    logic [9:0]        cfg_data;
    logic              done;
    logic [9:0]        out_column;
    logic              wall_hit;
    logic [16:0]       wall_distance;
    logic [11:0]       texture_u;
    logic signed [8:0] ceiling_row;
    logic [9:0]        floor_row;
    int                mismatch_count;
    int                pending_count;
    int                cycle_count;
    int                burst_left;

    grid_column_raycaster_top i_dut (.*);

    gcr_checker i_checker (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Abort the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Issue one request and hold it until the block takes it.
    task automatic send_request(logic act, logic [4:0] ridx, logic [31:0] bits,
                                logic [15:0] px, logic [15:0] py, logic [15:0] ang,
                                logic [9:0] col);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left = burst_left - 1;
        start         <= 1'b1;
        action        <= act;
        row_index     <= ridx;
        row_bits      <= bits;
        player_x      <= px;
        player_y      <= py;
        view_angle    <= ang;
        screen_column <= col;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic load_row(logic [4:0] ridx, logic [31:0] bits);
        send_request(ACT_LOAD, ridx, bits, 16'($urandom), 16'($urandom),
                     16'($urandom), 10'($urandom));
    endtask

    task automatic cast_ray(logic [15:0] px, logic [15:0] py, logic [15:0] ang,
                            logic [9:0] col);
        send_request(ACT_CAST, 5'($urandom), 32'($urandom), px, py, ang, col);
    endtask

    // Wait until every cast has returned, then let the block settle.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0 || busy);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [9:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // A random room: border with scattered pillars of the given density; about one row in ten is random bits instead.
    task automatic build_room(int density);
        logic [31:0] bits;
        for (int r = 0; r < MAP_HEIGHT; r++)
        begin
            bits = 32'h8000_0001;
            for (int c = 1; c < 31; c++)
                bits[c] = ($urandom_range(0, 99) < density);
            if (r == 0 || r == MAP_HEIGHT - 1)
                bits = 32'hFFFF_FFFF;
            if ($urandom_range(0, 9) == 0)
                bits = 32'($urandom);
            load_row(5'(r), bits);
        end
    endtask

    task automatic random_casts(int count, int map_kind);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 19) == 0)
                load_row(5'($urandom), 32'($urandom));
            else if (map_kind == 0)
                cast_ray(16'($urandom_range(2048, 63487)), 16'($urandom_range(2048, 63487)),
                         16'($urandom), 10'($urandom_range(0, 1022)));
            else
                cast_ray(16'($urandom), 16'($urandom), 16'($urandom),
                         10'($urandom_range(0, 1022)));
        end
    endtask

    initial
    begin
        cycle_count   = 0;
        burst_left    = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        action        = ACT_LOAD;
        row_index     = '0;
        row_bits      = '0;
        player_x      = '0;
        player_y      = '0;
        view_angle    = '0;
        screen_column = '0;
        cfg_valid     = 1'b0;
        cfg_addr      = CFG_SCREEN_WIDTH;
        cfg_data      = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Open floor at reset settings: rays leave the map or reach depth.
        cast_ray(16'd32768, 16'd32768, 16'd0, 10'd0);
        cast_ray(16'd0, 16'd0, 16'd32768, 10'd160);
        cast_ray(16'hFFFF, 16'hFFFF, 16'd16384, 10'd1022);
        cast_ray(16'd32768, 16'd32768, 16'hFFFF, 10'd319);
        drain();

        // Walls: full rows, a wall right in front, exact diagonals and corners.
        load_row(5'd0, 32'hFFFF_FFFF);
        load_row(5'd31, 32'hFFFF_FFFF);
        load_row(5'd16, 32'h0002_0000);
        load_row(5'd17, 32'h0000_0000);
        cast_ray(16'd32768, 16'd32768, 16'd49152, 10'd160);
        cast_ray(16'd34000, 16'd33792, 16'd0, 10'd160);
        cast_ray(16'd33792, 16'd33792, 16'd8192, 10'd160);
        cast_ray(16'd32768, 16'd2100, 16'd16384, 10'd0);
        cast_ray(16'd1024, 16'd1024, 16'd57344, 10'd160);
        drain();

        // Extreme settings: narrowest screen, lowest and highest heights.
        write_reg(CFG_SCREEN_WIDTH, 10'd1);
        write_reg(CFG_SCREEN_HEIGHT, 10'd2);
        write_reg(2'd2, 10'h3FF);
        cast_ray(16'd32768, 16'd32768, 16'd49152, 10'd1);
        cast_ray(16'd34816, 16'd34000, 16'd49152, 10'd0);
        drain();
        write_reg(CFG_SCREEN_WIDTH, 10'd0);
        write_reg(CFG_SCREEN_HEIGHT, 10'd511);
        cast_ray(16'd32768, 16'd33000, 16'd49152, 10'd1022);
        cast_ray(16'd32768, 16'd34000, 16'd49152, 10'd0);
        drain();

        // Random phases over several settings.
        write_reg(CFG_SCREEN_WIDTH, 10'd320);
        write_reg(CFG_SCREEN_HEIGHT, 10'd180);
        build_room(15);
        random_casts(70, 0);
        drain();
        write_reg(CFG_SCREEN_WIDTH, 10'd1023);
        write_reg(CFG_SCREEN_HEIGHT, 10'd511);
        build_room(30);
        random_casts(70, 0);
        drain();
        write_reg(CFG_SCREEN_WIDTH, 10'($urandom_range(1, 1023)));
        write_reg(CFG_SCREEN_HEIGHT, 10'($urandom_range(2, 511)));
        build_room(5);
        random_casts(70, 1);
        drain();
        write_reg(CFG_SCREEN_WIDTH, 10'd0);
        write_reg(CFG_SCREEN_HEIGHT, 10'd2);
        write_reg(2'd3, 10'($urandom));
        random_casts(40, 0);
        drain();

        if (mismatch_count == 0 && pending_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
design/gcr_pkg.sv
design/gcr_div.sv
design/gcr_dp.sv
design/gcr_ctrl.sv
design/grid_column_raycaster_top.sv
bench/gcr_checker.sv
bench/grid_column_raycaster_top_tb.sv
